### hw/rtl/fsla_pkg.sv
package fsla_pkg;

    localparam int IDX_W = 11;
    localparam int OFF_W = 21;
    localparam int LEN_W = 21;
    localparam logic [LEN_W-1:0] RESET_REGION = 21'd65536;
    localparam logic [LEN_W-1:0] MIN_REGION = 21'd64;
    localparam logic [LEN_W-1:0] MAX_REGION = 21'd1048576;
    localparam logic [20:0] MIN_REQ = 21'd16;
    localparam logic [3:0] MIN_ALIGN = 4'd3;
    localparam logic [3:0] MAX_ALIGN = 4'd12;

    localparam logic [1:0] SH_NONE = 2'd0;
    localparam logic [1:0] SH_INSERT = 2'd1;
    localparam logic [1:0] SH_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_FIT = 2'd1;
    localparam logic [1:0] ST_NOT_LIVE = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic [1:0] REG_BASE = 2'd0;
    localparam logic [1:0] REG_REGION = 2'd1;
    localparam logic [1:0] REG_POLICY = 2'd2;

    typedef struct packed {
        logic             wr;
        logic [IDX_W-1:0] wr_idx;
        logic [OFF_W-1:0] wr_start;
        logic [LEN_W-1:0] wr_len;
        logic [1:0]       shift;
        logic [IDX_W-1:0] sh_idx;
    } cell_cmd_t;

endpackage

### hw/rtl/free_list_segment_allocator_unit.sv
// An allocation walks the free segments for a fit, then the live slots for a free record;
// a free walks the live records for the address, then the free segments for its place.
// One request at a time; the walk over the segment cells and the live records sets how long each takes.
// The result sits in an output register, so the next request is taken while it waits.
// Reset (rst_n, async, active low): one free segment over the whole region, no live records,
// used and peak zero. Writing base_address or region_size does the same.
module free_list_segment_allocator_unit #(
    parameter int MAX_FREE_SEGMENTS = 32,
    parameter int MAX_LIVE_BLOCKS = 32,
    parameter int HEADER_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // req_size[20:0], align_log2[24:21], free_address[56:25]
    input  logic [0:0]  s_tuser,   // mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // status[1:0], data_address[33:2], used_bytes[54:34],
                                   // peak_bytes[75:55]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int SW = (MAX_FREE_SEGMENTS > 1) ? $clog2(MAX_FREE_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_FREE_SEGMENTS + 1);
    localparam int LW = (MAX_LIVE_BLOCKS > 1) ? $clog2(MAX_LIVE_BLOCKS) : 1;
    localparam int OW = fsla_pkg::OFF_W;
    localparam int NW = fsla_pkg::LEN_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FREE_SEGMENTS);
    localparam logic [LW-1:0] LAST_LIVE = LW'(MAX_LIVE_BLOCKS - 1);
    localparam logic [15:0] HDR = 16'(HEADER_BYTES);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SEARCH = 4'd1;
    localparam logic [3:0] S_SLOT = 4'd2;
    localparam logic [3:0] S_ALLOC = 4'd3;
    localparam logic [3:0] S_LOOKUP = 4'd4;
    localparam logic [3:0] S_FIND = 4'd5;
    localparam logic [3:0] S_FREE = 4'd6;
    localparam logic [3:0] S_DONE = 4'd7;

    logic [3:0] state_reg, state_next;
    logic [31:0] base_reg;
    logic [NW-1:0] region_reg;
    logic policy_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] p_reg, p_next;
    logic [LW-1:0] k_reg, k_next;
    logic [20:0] used_reg, used_next, peak_reg, peak_next;

    logic mode_reg;
    logic [20:0] req_reg;
    logic [3:0] alog_reg;
    logic [31:0] faddr_reg;

    logic found_reg, found_next;
    logic [SW-1:0] best_reg, best_next;
    logic [NW-1:0] slack_reg, slack_next;
    logic [21:0] bneed_reg, bneed_next;
    logic [15:0] bpad_reg, bpad_next;

    logic [OW-1:0] fs_reg, fs_next;
    logic [NW-1:0] fl_reg, fl_next;

    logic [1:0] status_reg, status_next;
    logic [31:0] daddr_reg, daddr_next;
    logic m_valid_reg;
    logic [79:0] m_data_reg;

    logic [OW-1:0] live_seg [MAX_LIVE_BLOCKS];
    logic [NW-1:0] live_len [MAX_LIVE_BLOCKS];
    logic [21:0] live_data [MAX_LIVE_BLOCKS];
    logic [MAX_LIVE_BLOCKS-1:0] live_valid_reg;
    logic live_wr, live_clr, live_reset;

    fsla_pkg::cell_cmd_t cmd, fsm_cmd;
    logic [OW-1:0] c_start [MAX_FREE_SEGMENTS];
    logic [NW-1:0] c_len [MAX_FREE_SEGMENTS];

    logic cfg_reinit;
    logic [NW-1:0] cfg_region;
    logic [20:0] cfg_v;

    // cell chain
    for (genvar g = 0; g < MAX_FREE_SEGMENTS; g++)
    begin : g_cell
        logic [OW-1:0] ls, rs;
        logic [NW-1:0] ll, rl;
        if (g == 0)
        begin : g_first
            assign ls = '0;
            assign ll = '0;
        end
        else
        begin : g_mid
            assign ls = c_start[g-1];
            assign ll = c_len[g-1];
        end
        if (g == MAX_FREE_SEGMENTS - 1)
        begin : g_last
            assign rs = '0;
            assign rl = '0;
        end
        else
        begin : g_inner
            assign rs = c_start[g+1];
            assign rl = c_len[g+1];
        end
        fsla_cell #(.IDX(g)) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_start  (ls),
            .left_len    (ll),
            .right_start (rs),
            .right_len   (rl),
            .start       (c_start[g]),
            .len         (c_len[g])
        );
    end

    // configuration
    assign cfg_ready = 1'b1;
    assign cfg_v = cfg_data[20:0];
    always_comb
    begin
        cfg_region = cfg_v;
        if (cfg_v < fsla_pkg::MIN_REGION)
            cfg_region = fsla_pkg::MIN_REGION;
        else if (cfg_v > fsla_pkg::MAX_REGION)
            cfg_region = fsla_pkg::MAX_REGION;
    end
    assign cfg_reinit = cfg_valid &&
        (cfg_index == fsla_pkg::REG_BASE || cfg_index == fsla_pkg::REG_REGION);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            region_reg <= fsla_pkg::RESET_REGION;
            policy_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fsla_pkg::REG_BASE: base_reg <= {cfg_data[31:3], 3'b000};
                fsla_pkg::REG_REGION: region_reg <= cfg_region;
                fsla_pkg::REG_POLICY: policy_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cmd = fsm_cmd;
        if (cfg_reinit)
        begin
            cmd.wr = 1'b1;
            cmd.wr_idx = '0;
            cmd.wr_start = '0;
            cmd.wr_len = (cfg_index == fsla_pkg::REG_REGION) ? cfg_region : region_reg;
            cmd.shift = fsla_pkg::SH_NONE;
            cmd.sh_idx = '0;
        end
    end

    // per-segment fit
    logic [SW-1:0] pi, pm1;
    logic p_in;
    logic [OW-1:0] cur_start;
    logic [NW-1:0] cur_len;
    logic [11:0] a_low;
    logic [15:0] amask, p0, pad, hneed;
    logic [21:0] need;
    logic fits;
    logic [NW-1:0] slack;

    assign pi = p_reg[SW-1:0];
    assign pm1 = SW'(p_reg - CW'(1));
    assign p_in = p_reg < count_reg;
    assign cur_start = c_start[pi];
    assign cur_len = c_len[pi];
    assign a_low = base_reg[11:0] + cur_start[11:0];
    assign amask = (16'd1 << alog_reg) - 16'd1;

    always_comb
    begin
        p0 = (16'd4096 - {4'd0, a_low}) & amask;
        hneed = HDR - p0;
        pad = p0;
        if (p0 < HDR)
            pad = p0 + (((hneed + amask) >> alog_reg) << alog_reg);
    end
    assign need = {1'b0, req_reg} + {6'd0, pad};
    assign fits = {1'b0, cur_len} >= need;
    assign slack = cur_len - need[NW-1:0];

    // free merge view
    logic [OW-1:0] prv_start;
    logic [NW-1:0] prv_len;
    logic mprev, mnext;
    assign prv_start = c_start[pm1];
    assign prv_len = c_len[pm1];
    assign mprev = (p_reg != '0) && ({1'b0, prv_start} + {1'b0, prv_len} == {1'b0, fs_reg});
    assign mnext = p_in && ({1'b0, fs_reg} + {1'b0, fl_reg} == {1'b0, cur_start});

    logic live_match;
    logic [31:0] live_addr;
    assign live_addr = base_reg + {10'd0, live_data[k_reg]};
    assign live_match = live_valid_reg[k_reg] && live_addr == faddr_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        p_next = p_reg;
        k_next = k_reg;
        used_next = used_reg;
        peak_next = peak_reg;
        found_next = found_reg;
        best_next = best_reg;
        slack_next = slack_reg;
        bneed_next = bneed_reg;
        bpad_next = bpad_reg;
        fs_next = fs_reg;
        fl_next = fl_reg;
        status_next = status_reg;
        daddr_next = daddr_reg;
        live_wr = 1'b0;
        live_clr = 1'b0;
        fsm_cmd = '0;
        fsm_cmd.shift = fsla_pkg::SH_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                p_next = '0;
                k_next = '0;
                found_next = 1'b0;
                daddr_next = '0;
                if (s_tvalid)
                    state_next = s_tuser[0] ? S_LOOKUP : S_SEARCH;
            end
            S_SEARCH:
            begin
                if (!p_in)
                begin
                    status_next = fsla_pkg::ST_NO_FIT;
                    state_next = S_DONE;
                end
                else
                begin
                    if (fits && (!found_reg || slack < slack_reg))
                    begin
                        found_next = 1'b1;
                        best_next = pi;
                        slack_next = slack;
                        bneed_next = need;
                        bpad_next = pad;
                    end
                    if ((fits && !policy_reg) || (p_reg + CW'(1) >= count_reg))
                    begin
                        if (fits || found_reg)
                            state_next = S_SLOT;
                        else
                        begin
                            status_next = fsla_pkg::ST_NO_FIT;
                            state_next = S_DONE;
                        end
                    end
                    else
                        p_next = p_reg + CW'(1);
                end
            end
            S_SLOT:
            begin
                if (!live_valid_reg[k_reg])
                    state_next = S_ALLOC;
                else if (k_reg == LAST_LIVE)
                begin
                    status_next = fsla_pkg::ST_FULL;
                    state_next = S_DONE;
                end
                else
                    k_next = k_reg + LW'(1);
            end
            S_ALLOC:
            begin
                live_wr = 1'b1;
                daddr_next = base_reg + 32'(c_start[best_reg]) + 32'(bpad_reg);
                if (slack_reg != '0)
                begin
                    fsm_cmd.wr = 1'b1;
                    fsm_cmd.wr_idx = fsla_pkg::IDX_W'(best_reg);
                    fsm_cmd.wr_start = c_start[best_reg] + bneed_reg[OW-1:0];
                    fsm_cmd.wr_len = slack_reg;
                end
                else
                begin
                    fsm_cmd.shift = fsla_pkg::SH_REMOVE;
                    fsm_cmd.sh_idx = fsla_pkg::IDX_W'(best_reg);
                    count_next = count_reg - CW'(1);
                end
                used_next = used_reg + bneed_reg[20:0];
                if (used_reg + bneed_reg[20:0] > peak_reg)
                    peak_next = used_reg + bneed_reg[20:0];
                status_next = fsla_pkg::ST_OK;
                state_next = S_DONE;
            end
            S_LOOKUP:
            begin
                if (live_match)
                begin
                    fs_next = live_seg[k_reg];
                    fl_next = live_len[k_reg];
                    state_next = S_FIND;
                end
                else if (k_reg == LAST_LIVE)
                begin
                    status_next = fsla_pkg::ST_NOT_LIVE;
                    state_next = S_DONE;
                end
                else
                    k_next = k_reg + LW'(1);
            end
            S_FIND:
            begin
                if (p_in && cur_start <= fs_reg)
                    p_next = p_reg + CW'(1);
                else
                    state_next = S_FREE;
            end
            S_FREE:
            begin
                status_next = fsla_pkg::ST_OK;
                priority if (mprev && mnext)
                begin
                    fsm_cmd.wr = 1'b1;
                    fsm_cmd.wr_idx = fsla_pkg::IDX_W'(pm1);
                    fsm_cmd.wr_start = prv_start;
                    fsm_cmd.wr_len = prv_len + fl_reg + cur_len;
                    fsm_cmd.shift = fsla_pkg::SH_REMOVE;
                    fsm_cmd.sh_idx = fsla_pkg::IDX_W'(pi);
                    count_next = count_reg - CW'(1);
                end
                else if (mprev)
                begin
                    fsm_cmd.wr = 1'b1;
                    fsm_cmd.wr_idx = fsla_pkg::IDX_W'(pm1);
                    fsm_cmd.wr_start = prv_start;
                    fsm_cmd.wr_len = prv_len + fl_reg;
                end
                else if (mnext)
                begin
                    fsm_cmd.wr = 1'b1;
                    fsm_cmd.wr_idx = fsla_pkg::IDX_W'(pi);
                    fsm_cmd.wr_start = fs_reg;
                    fsm_cmd.wr_len = cur_len + fl_reg;
                end
                else if (count_reg >= MAX_CNT)
                    status_next = fsla_pkg::ST_FULL;
                else
                begin
                    fsm_cmd.wr = 1'b1;
                    fsm_cmd.wr_idx = fsla_pkg::IDX_W'(p_reg);
                    fsm_cmd.wr_start = fs_reg;
                    fsm_cmd.wr_len = fl_reg;
                    fsm_cmd.shift = fsla_pkg::SH_INSERT;
                    fsm_cmd.sh_idx = fsla_pkg::IDX_W'(p_reg);
                    count_next = count_reg + CW'(1);
                end
                if (mprev || mnext || count_reg < MAX_CNT)
                begin
                    live_clr = 1'b1;
                    used_next = used_reg - fl_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign live_reset = cfg_reinit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CW'(1);
            used_reg <= '0;
            peak_reg <= '0;
            live_valid_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (live_reset)
            begin
                count_reg <= CW'(1);
                used_reg <= '0;
                peak_reg <= '0;
                live_valid_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
                used_reg <= used_next;
                peak_reg <= peak_next;
                if (live_wr)
                    live_valid_reg[k_reg] <= 1'b1;
                if (live_clr)
                    live_valid_reg[k_reg] <= 1'b0;
            end
            if (state_reg == S_DONE && (!m_valid_reg || m_tready))
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        k_reg <= k_next;
        found_reg <= found_next;
        best_reg <= best_next;
        slack_reg <= slack_next;
        bneed_reg <= bneed_next;
        bpad_reg <= bpad_next;
        fs_reg <= fs_next;
        fl_reg <= fl_next;
        status_reg <= status_next;
        daddr_reg <= daddr_next;
        if (state_reg == S_IDLE && s_tvalid)
        begin
            mode_reg <= s_tuser[0];
            req_reg <= (s_tdata[20:0] < fsla_pkg::MIN_REQ) ? fsla_pkg::MIN_REQ : s_tdata[20:0];
            alog_reg <= (s_tdata[24:21] < fsla_pkg::MIN_ALIGN) ? fsla_pkg::MIN_ALIGN :
                        (s_tdata[24:21] > fsla_pkg::MAX_ALIGN) ? fsla_pkg::MAX_ALIGN :
                        s_tdata[24:21];
            faddr_reg <= s_tdata[56:25];
        end
        if (live_wr)
        begin
            live_seg[k_reg] <= c_start[best_reg];
            live_len[k_reg] <= bneed_reg[NW-1:0];
            live_data[k_reg] <= 22'(c_start[best_reg]) + 22'(bpad_reg);
        end
        if (state_reg == S_DONE && (!m_valid_reg || m_tready))
            m_data_reg <= {4'd0, peak_reg, used_reg,
                           (mode_reg ? 32'd0 : daddr_reg), status_reg};
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT) else $error("free segment count above table size");
    a_peak_used: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= used_reg) else $error("peak below used bytes");
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !m_valid_reg) |=> m_valid_reg)
        else $error("finished request not presented");
`endif

endmodule

### hw/rtl/fsla_cell.sv
module fsla_cell #(
    parameter int IDX = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fsla_pkg::cell_cmd_t             cmd,
    input  logic [fsla_pkg::OFF_W-1:0]      left_start,
    input  logic [fsla_pkg::LEN_W-1:0]      left_len,
    input  logic [fsla_pkg::OFF_W-1:0]      right_start,
    input  logic [fsla_pkg::LEN_W-1:0]      right_len,
    output logic [fsla_pkg::OFF_W-1:0]      start,
    output logic [fsla_pkg::LEN_W-1:0]      len
);

    localparam logic [fsla_pkg::IDX_W-1:0] MY_IDX = fsla_pkg::IDX_W'(IDX);

    logic [fsla_pkg::OFF_W-1:0] start_reg, start_next;
    logic [fsla_pkg::LEN_W-1:0] len_reg, len_next;

    always_comb
    begin
        start_next = start_reg;
        len_next = len_reg;
        priority if (cmd.wr && cmd.wr_idx == MY_IDX)
        begin
            start_next = cmd.wr_start;
            len_next = cmd.wr_len;
        end
        else if (cmd.shift == fsla_pkg::SH_INSERT && MY_IDX > cmd.sh_idx)
        begin
            start_next = left_start;
            len_next = left_len;
        end
        else if (cmd.shift == fsla_pkg::SH_REMOVE && MY_IDX >= cmd.sh_idx)
        begin
            start_next = right_start;
            len_next = right_len;
        end
        else
        begin
            // hold
            start_next = start_reg;
            len_next = len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            len_reg <= fsla_pkg::RESET_REGION;
        end
        else
        begin
            start_reg <= start_next;
            len_reg <= len_next;
        end
    end

    assign start = start_reg;
    assign len = len_reg;

endmodule
